/* hw/rtl/sb2dec_pkg.sv */
// shared constants and types for the signed binary to decimal ascii converter
`timescale 1ns / 1ps

package sb2dec_pkg;

   // width of the converted word (8 to 64)
   localparam int WORD_WIDTH = 32;

   // fixed port widths
   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 6;

   // decimal digits needed for 2^WORD_WIDTH, floor(w * log10(2)) + 1
   localparam int DIGIT_COUNT     = (WORD_WIDTH * 1233) / 4096 + 1;
   localparam int DIGIT_IDX_WIDTH = $clog2(DIGIT_COUNT);
   localparam int BIT_CNT_WIDTH   = $clog2(WORD_WIDTH);

   // ascii codes, truncated to the character port width
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = CHAR_WIDTH'(45);
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = CHAR_WIDTH'(48);

   // packed bcd register, one nibble per decimal digit
   typedef logic [DIGIT_COUNT-1:0][3:0] bcd_type;

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

endpackage

/* hw/rtl/sb2dec_bcd_step.sv */
// one double-dabble step: add-3 correction on every digit, then shift one bit in
`timescale 1ns / 1ps

module sb2dec_bcd_step (
   input  sb2dec_pkg::bcd_type bcd_in,
   input  logic                bit_in,
   output sb2dec_pkg::bcd_type bcd_out
);
   import sb2dec_pkg::*;

   bcd_type                  adj;
   logic [4*DIGIT_COUNT-1:0] adj_bits;

   // digits of five or more get three added so the shift carries correctly
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_in[i] >= 4'd5) begin
            adj[i] = bcd_in[i] + 4'd3;
         end else begin
            adj[i] = bcd_in[i];
         end
      end
   end

   // shift the whole bcd vector left, new binary bit enters at the bottom
   assign adj_bits = adj;
   assign bcd_out  = {adj_bits[4*DIGIT_COUNT-2:0], bit_in};

endmodule

/* hw/rtl/signed_binary_to_decimal_ascii.sv */
// top level: signed integer to decimal ascii character stream
//
// Takes one signed integer per request word (the low WORD_WIDTH bits of
// req_value, two's complement) and returns its decimal text as response
// words, most significant first: '-' for negative values, then the digits
// with no leading zeros, zero giving a single '0'. rsp_last marks the final
// character. The most negative value prints its full magnitude. One number
// is handled at a time: after acceptance req_stall stays high until the
// last character has been loaded into the output register. A number is
// shifted bit by bit through the shared double-dabble shift unit, then
// leading zero digit positions are skipped, the sign is sent when the
// number is negative and the remaining digits are emitted, after which
// the sequencer returns to idle, where the next word is taken; rsp_stall
// holds the sign and emit phases.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sb2dec_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sb2dec_pkg::CHAR_WIDTH-1:0]     rsp_character,
   output logic                                  rsp_last
);
   import sb2dec_pkg::*;

   logic [2:0]                 state_ff, state_in;
   logic [WORD_WIDTH-1:0]      mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   bcd_type                    bcd_ff, bcd_in;
   logic [BIT_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [DIGIT_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]      rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [WORD_WIDTH-1:0]      word_x;
   logic                       word_neg;
   bcd_type                    bcd_next;
   logic [3:0]                 cur_digit;
   logic                       out_free;

   // shared shift-and-correct unit
   sb2dec_bcd_step u_step (
      .bcd_in  (bcd_ff),
      .bit_in  (mag_ff[WORD_WIDTH-1]),
      .bcd_out (bcd_next)
   );

   // input word at the converter width, sign and magnitude
   assign word_x   = WORD_WIDTH'($unsigned(req_value));
   assign word_neg = word_x[WORD_WIDTH-1];

   assign cur_digit = bcd_ff[idx_ff];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in   = word_neg;
               mag_in   = word_neg ? WORD_WIDTH'(~word_x + 1'b1) : word_x;
               bcd_in   = '0;
               cnt_in   = BIT_CNT_WIDTH'(WORD_WIDTH - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_next;
            mag_in = {mag_ff[WORD_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               idx_in   = DIGIT_IDX_WIDTH'(DIGIT_COUNT - 1);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cur_digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + CHAR_WIDTH'(cur_digit);
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // an accepted word always starts a conversion
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CONV)
      else $error("accepted word did not start conversion");

   // conversion ends after the last bit has been shifted in
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV && cnt_ff == '0 |=> state_ff == ST_SKIP)
      else $error("conversion did not end on the final bit");

   // a minus sign is never the final character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last");

   // every other character is a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character != CHAR_MINUS |->
         rsp_character >= CHAR_ZERO && rsp_character <= CHAR_ZERO + CHAR_WIDTH'(9))
      else $error("character out of digit range");

endmodule
